FILE: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_STEPS   = 32;

    // 180 degrees with 24 fraction bits
    localparam logic signed [35:0] ANG180   = 36'sd3019898880;
    localparam logic signed [35:0] ANG90    = 36'sd1509949440;
    localparam logic signed [35:0] DEG180_Q = 36'sd11796480;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_MUL  = 3'd1,
        OP_CDIV = 3'd2,
        OP_RDIV = 3'd3,
        OP_MOD  = 3'd4,
        OP_ARG  = 3'd5
    } op_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic signed [31:0] xr;
        logic signed [31:0] xi;
        logic signed [31:0] yr;
        logic signed [31:0] yi;
    } a_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               dz;
        logic signed [31:0] xr;
        logic signed [31:0] xi;
        logic signed [31:0] yr;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] p5;
        sat_t               add_re;
        sat_t               add_im;
    } b_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               dz;
        logic signed [31:0] xr;
        logic signed [31:0] xi;
        logic signed [64:0] s_re;
        logic signed [64:0] s_im;
        logic               neg_fix;
        logic [63:0]        d;
        sat_t               add_re;
        sat_t               add_im;
    } c_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               dz;
        logic signed [31:0] xr;
        logic signed [31:0] xi;
        logic               neg_re;
        logic               neg_im;
        logic [63:0]        mag_re;
        logic [63:0]        mag_im;
        logic [63:0]        d;
        sat_t               add_re;
        sat_t               add_im;
    } d_t;

    typedef struct packed {
        logic               valid;
        op_t                op;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        sat_t               pre_re;
        sat_t               pre_im;
        logic [63:0]        d;
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [31:0]        low_re;
        logic [31:0]        low_im;
        logic [31:0]        q_re;
        logic [31:0]        q_im;
        logic [63:0]        sq_s;
        logic [63:0]        sq_res;
        logic signed [59:0] cx;
        logic signed [59:0] cy;
        logic signed [35:0] cz;
        logic               c_hold;
    } it_t;

    // saturate a sign and magnitude to the signed 32-bit range
    function automatic sat_t clamp_mag(input logic neg, input logic [63:0] mag);
        sat_t r;
        r.sat = 1'b0;
        r.val = 32'd0;
        if (!neg)
        begin
            if (mag > 64'h7fff_ffff)
            begin
                r.sat = 1'b1;
                r.val = 32'h7fff_ffff;
            end
            else
            begin
                r.val = mag[31:0];
            end
        end
        else
        begin
            if (mag > 64'h8000_0000)
            begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end
            else
            begin
                r.val = 32'd0 - mag[31:0];
            end
        end
        return r;
    endfunction

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [35:0] atan_deg(input int i);
        logic signed [35:0] v;
        case (i)
            0:       v = 36'sd754974720;
            1:       v = 36'sd445687602;
            2:       v = 36'sd235489088;
            3:       v = 36'sd119537938;
            4:       v = 36'sd60000934;
            5:       v = 36'sd30029717;
            6:       v = 36'sd15018523;
            7:       v = 36'sd7509720;
            8:       v = 36'sd3754917;
            9:       v = 36'sd1877466;
            10:      v = 36'sd938734;
            11:      v = 36'sd469367;
            12:      v = 36'sd234684;
            13:      v = 36'sd117342;
            14:      v = 36'sd58671;
            15:      v = 36'sd29335;
            16:      v = 36'sd14668;
            17:      v = 36'sd7334;
            18:      v = 36'sd3667;
            19:      v = 36'sd1833;
            20:      v = 36'sd917;
            21:      v = 36'sd458;
            22:      v = 36'sd229;
            23:      v = 36'sd115;
            24:      v = 36'sd57;
            25:      v = 36'sd29;
            26:      v = 36'sd14;
            27:      v = 36'sd7;
            28:      v = 36'sd4;
            29:      v = 36'sd2;
            30:      v = 36'sd1;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/complex_arith_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// Pipelined complex ALU on Q16.16 operands: add, multiply, divide, modulus,
// argument.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_stall carries op, x_re, x_im, y_re, y_im
//   output channel out_valid / out_stall carries res_re, res_im,
//   div_by_zero and saturated
//   a transfer takes place at a clock edge with valid high and stall low
// Throughput: one item per cycle while out_stall does not hold the pipeline;
//   every opcode takes the same path through stages a to d, the iteration
//   stages and the output register. The depth is set by the 32 stages of the
//   long divider and square root, one quotient bit or root bit per stage;
//   the 24 CORDIC steps run in the first 24 of those stages.
// Stall: when a result waits under out_stall the whole pipeline holds and
//   in_stall rises; nothing is lost or repeated.
// Reset: rst_n clears all valid bits; the pipeline starts empty.
// ----------------------------------------------------------------------------
module complex_arith_unit_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] x_re,
    input  logic signed [31:0] x_im,
    input  logic signed [31:0] y_re,
    input  logic signed [31:0] y_im,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               div_by_zero,
    output logic               saturated
);

    localparam int ITER = cau_pkg::ITER_STEPS;

    logic adv;

    cau_pkg::a_t a_reg, a_next;
    cau_pkg::b_t b_reg, b_next;
    cau_pkg::c_t c_reg, c_next;
    cau_pkg::d_t d_reg, d_next;
    cau_pkg::it_t it_reg [0:ITER];
    cau_pkg::it_t it_next [0:ITER];

    logic               out_valid_reg;
    logic signed [31:0] res_re_reg, res_re_next;
    logic signed [31:0] res_im_reg, res_im_next;
    logic               dz_reg, dz_next;
    logic               sat_reg, sat_next;

    assign in_stall = out_valid_reg && out_stall;
    assign adv      = !in_stall;

    // stage a: input register
    always_comb
    begin
        a_next.valid = in_valid;
        a_next.op    = cau_pkg::op_t'(op);
        a_next.xr    = x_re;
        a_next.xi    = x_im;
        a_next.yr    = y_re;
        a_next.yi    = y_im;
    end

    // stage b: products, sum, zero checks
    always_comb
    begin
        logic signed [31:0] ma;
        logic signed [31:0] mb;
        logic signed [32:0] sr;
        logic signed [32:0] si;
        logic [32:0]        ur;
        logic [32:0]        ui;
        ma = (a_reg.op == cau_pkg::OP_MOD) ? a_reg.xr : a_reg.yr;
        mb = (a_reg.op == cau_pkg::OP_MOD) ? a_reg.xi : a_reg.yi;
        sr = {a_reg.xr[31], a_reg.xr} + {a_reg.yr[31], a_reg.yr};
        si = {a_reg.xi[31], a_reg.xi} + {a_reg.yi[31], a_reg.yi};
        ur = sr[32] ? 33'd0 - sr : sr;
        ui = si[32] ? 33'd0 - si : si;
        b_next.valid  = a_reg.valid;
        b_next.op     = a_reg.op;
        b_next.xr     = a_reg.xr;
        b_next.xi     = a_reg.xi;
        b_next.yr     = a_reg.yr;
        b_next.p0     = a_reg.xr * a_reg.yr;
        b_next.p1     = a_reg.xi * a_reg.yi;
        b_next.p2     = a_reg.xr * a_reg.yi;
        b_next.p3     = a_reg.xi * a_reg.yr;
        b_next.p4     = ma * ma;
        b_next.p5     = mb * mb;
        b_next.add_re = cau_pkg::clamp_mag(sr[32], {31'd0, ur});
        b_next.add_im = cau_pkg::clamp_mag(si[32], {31'd0, ui});
        case (a_reg.op)
            cau_pkg::OP_CDIV: b_next.dz = (a_reg.yr == 32'sd0) && (a_reg.yi == 32'sd0);
            cau_pkg::OP_RDIV: b_next.dz = (a_reg.yr == 32'sd0);
            cau_pkg::OP_ARG:  b_next.dz = (a_reg.xr == 32'sd0) && (a_reg.xi == 32'sd0);
            default:          b_next.dz = 1'b0;
        endcase
    end

    // stage c: wide sums, divisor or radicand
    always_comb
    begin
        logic signed [64:0] e0;
        logic signed [64:0] e1;
        logic signed [64:0] e2;
        logic signed [64:0] e3;
        logic [31:0]        yr_mag;
        e0 = {b_reg.p0[63], b_reg.p0};
        e1 = {b_reg.p1[63], b_reg.p1};
        e2 = {b_reg.p2[63], b_reg.p2};
        e3 = {b_reg.p3[63], b_reg.p3};
        yr_mag = b_reg.yr[31] ? 32'd0 - b_reg.yr : b_reg.yr;
        c_next.valid   = b_reg.valid;
        c_next.op      = b_reg.op;
        c_next.dz      = b_reg.dz;
        c_next.xr      = b_reg.xr;
        c_next.xi      = b_reg.xi;
        c_next.add_re  = b_reg.add_re;
        c_next.add_im  = b_reg.add_im;
        c_next.neg_fix = (b_reg.op == cau_pkg::OP_RDIV) && b_reg.yr[31];
        c_next.d       = 64'(b_reg.p4) + 64'(b_reg.p5);
        case (b_reg.op)
            cau_pkg::OP_MUL:
            begin
                c_next.s_re = e0 - e1;
                c_next.s_im = e2 + e3;
            end
            cau_pkg::OP_CDIV:
            begin
                c_next.s_re = e0 + e1;
                c_next.s_im = e3 - e2;
            end
            cau_pkg::OP_RDIV:
            begin
                c_next.s_re = 65'(b_reg.xr);
                c_next.s_im = 65'(b_reg.xi);
                c_next.d    = {32'd0, yr_mag};
            end
            default:
            begin
                c_next.s_re = 65'sd0;
                c_next.s_im = 65'sd0;
            end
        endcase
    end

    // stage d: sign and magnitude
    always_comb
    begin
        logic [64:0] ur;
        logic [64:0] ui;
        ur = c_reg.s_re[64] ? 65'd0 - c_reg.s_re : c_reg.s_re;
        ui = c_reg.s_im[64] ? 65'd0 - c_reg.s_im : c_reg.s_im;
        d_next.valid  = c_reg.valid;
        d_next.op     = c_reg.op;
        d_next.dz     = c_reg.dz;
        d_next.xr     = c_reg.xr;
        d_next.xi     = c_reg.xi;
        d_next.neg_re = c_reg.s_re[64] ^ c_reg.neg_fix;
        d_next.neg_im = c_reg.s_im[64] ^ c_reg.neg_fix;
        d_next.mag_re = ur[63:0];
        d_next.mag_im = ui[63:0];
        d_next.d      = c_reg.d;
        d_next.add_re = c_reg.add_re;
        d_next.add_im = c_reg.add_im;
    end

    // stage e: overflow checks, product truncation, divider / root / cordic setup
    always_comb
    begin
        cau_pkg::it_t       t;
        logic signed [59:0] x0;
        logic signed [59:0] y0;
        x0 = {{4{d_reg.xr[31]}}, d_reg.xr, 24'd0};
        y0 = {{4{d_reg.xi[31]}}, d_reg.xi, 24'd0};
        t.valid  = d_reg.valid;
        t.op     = d_reg.op;
        t.dz     = d_reg.dz;
        t.neg_re = d_reg.neg_re;
        t.neg_im = d_reg.neg_im;
        t.ovf_re = ({16'd0, d_reg.mag_re[63:cau_pkg::FRAC_BITS]} >= d_reg.d);
        t.ovf_im = ({16'd0, d_reg.mag_im[63:cau_pkg::FRAC_BITS]} >= d_reg.d);
        if (d_reg.op == cau_pkg::OP_MUL)
        begin
            t.pre_re = cau_pkg::clamp_mag(d_reg.neg_re,
                {16'd0, d_reg.mag_re[63:cau_pkg::FRAC_BITS]});
            t.pre_im = cau_pkg::clamp_mag(d_reg.neg_im,
                {16'd0, d_reg.mag_im[63:cau_pkg::FRAC_BITS]});
        end
        else
        begin
            t.pre_re = d_reg.add_re;
            t.pre_im = d_reg.add_im;
        end
        t.d      = d_reg.d;
        t.rem_re = {16'd0, d_reg.mag_re[63:cau_pkg::FRAC_BITS]};
        t.rem_im = {16'd0, d_reg.mag_im[63:cau_pkg::FRAC_BITS]};
        t.low_re = {d_reg.mag_re[cau_pkg::FRAC_BITS-1:0], 16'd0};
        t.low_im = {d_reg.mag_im[cau_pkg::FRAC_BITS-1:0], 16'd0};
        t.q_re   = 32'd0;
        t.q_im   = 32'd0;
        t.sq_s   = d_reg.d;
        t.sq_res = 64'd0;
        t.cx     = x0;
        t.cy     = y0;
        t.cz     = 36'sd0;
        t.c_hold = 1'b1;
        // axis directions are exact
        if (d_reg.xi == 32'sd0)
        begin
            t.cz = (d_reg.xr > 32'sd0) ? 36'sd0 : cau_pkg::ANG180;
        end
        else if (d_reg.xr == 32'sd0)
        begin
            t.cz = (d_reg.xi > 32'sd0) ? cau_pkg::ANG90 : -cau_pkg::ANG90;
        end
        else
        begin
            t.c_hold = 1'b0;
            if (d_reg.xr < 32'sd0)
            begin
                t.cz = (d_reg.xi > 32'sd0) ? cau_pkg::ANG180 : -cau_pkg::ANG180;
                t.cx = -x0;
                t.cy = -y0;
            end
        end
        it_next[0] = t;
    end

    // iteration stages: one quotient bit and one root bit each, and in the first 24 one cordic step
    for (genvar k = 0; k < ITER; k++)
    begin : g_iter
        always_comb
        begin
            cau_pkg::it_t       t;
            logic [63:0]        sh;
            logic [63:0]        rbit;
            logic [63:0]        trial;
            logic signed [59:0] dx;
            logic signed [59:0] dy;
            t = it_reg[k];

            sh = {t.rem_re[62:0], t.low_re[31]};
            if (sh >= t.d)
            begin
                t.rem_re = sh - t.d;
                t.q_re   = {t.q_re[30:0], 1'b1};
            end
            else
            begin
                t.rem_re = sh;
                t.q_re   = {t.q_re[30:0], 1'b0};
            end
            t.low_re = {t.low_re[30:0], 1'b0};

            sh = {t.rem_im[62:0], t.low_im[31]};
            if (sh >= t.d)
            begin
                t.rem_im = sh - t.d;
                t.q_im   = {t.q_im[30:0], 1'b1};
            end
            else
            begin
                t.rem_im = sh;
                t.q_im   = {t.q_im[30:0], 1'b0};
            end
            t.low_im = {t.low_im[30:0], 1'b0};

            rbit  = 64'd1 << (62 - 2 * k);
            trial = t.sq_res + rbit;
            if (t.sq_s >= trial)
            begin
                t.sq_s   = t.sq_s - trial;
                t.sq_res = (t.sq_res >> 1) + rbit;
            end
            else
            begin
                t.sq_res = t.sq_res >> 1;
            end

            dx = t.cy >>> k;
            dy = t.cx >>> k;
            if (k < cau_pkg::CORDIC_STEPS && !t.c_hold)
            begin
                if (t.cy > 60'sd0)
                begin
                    t.cx = t.cx + dx;
                    t.cy = t.cy - dy;
                    t.cz = t.cz + cau_pkg::atan_deg(k);
                end
                else
                begin
                    t.cx = t.cx - dx;
                    t.cy = t.cy + dy;
                    t.cz = t.cz - cau_pkg::atan_deg(k);
                end
            end
            it_next[k + 1] = t;
        end
    end

    // result selection
    always_comb
    begin
        cau_pkg::it_t       f;
        cau_pkg::sat_t      cr;
        cau_pkg::sat_t      ci;
        logic signed [35:0] r;
        f = it_reg[ITER];
        cr = cau_pkg::clamp_mag(f.neg_re, f.ovf_re ? 64'hffff_ffff_ffff_ffff
                                                   : {32'd0, f.q_re});
        ci = cau_pkg::clamp_mag(f.neg_im, f.ovf_im ? 64'hffff_ffff_ffff_ffff
                                                   : {32'd0, f.q_im});
        r = (f.cz + 36'sd128) >>> 8;
        if (r <= -cau_pkg::DEG180_Q)
        begin
            r = r + 2 * cau_pkg::DEG180_Q;
        end
        if (r > cau_pkg::DEG180_Q)
        begin
            r = r - 2 * cau_pkg::DEG180_Q;
        end
        res_re_next = 32'sd0;
        res_im_next = 32'sd0;
        dz_next     = 1'b0;
        sat_next    = 1'b0;
        case (f.op)
            cau_pkg::OP_ADD, cau_pkg::OP_MUL:
            begin
                res_re_next = f.pre_re.val;
                res_im_next = f.pre_im.val;
                sat_next    = f.pre_re.sat | f.pre_im.sat;
            end
            cau_pkg::OP_CDIV, cau_pkg::OP_RDIV:
            begin
                if (f.dz)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    res_re_next = cr.val;
                    res_im_next = ci.val;
                    sat_next    = cr.sat | ci.sat;
                end
            end
            cau_pkg::OP_MOD:
            begin
                cr          = cau_pkg::clamp_mag(1'b0, f.sq_res);
                res_re_next = cr.val;
                sat_next    = cr.sat;
            end
            cau_pkg::OP_ARG:
            begin
                if (f.dz)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    res_re_next = r[31:0];
                end
            end
            default:
            begin
                res_re_next = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg.valid   <= 1'b0;
            b_reg.valid   <= 1'b0;
            c_reg.valid   <= 1'b0;
            d_reg.valid   <= 1'b0;
            for (int i = 0; i <= ITER; i++)
            begin
                it_reg[i].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            for (int i = 0; i <= ITER; i++)
            begin
                it_reg[i] <= it_next[i];
            end
            out_valid_reg <= it_reg[ITER].valid;
            res_re_reg    <= res_re_next;
            res_im_reg    <= res_im_next;
            dz_reg        <= dz_next;
            sat_reg       <= sat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_re      = res_re_reg;
    assign res_im      = res_im_reg;
    assign div_by_zero = dz_reg;
    assign saturated   = sat_reg;

    logic [ITER + 4:0] valid_vec;
    always_comb
    begin
        valid_vec[0] = a_reg.valid;
        valid_vec[1] = b_reg.valid;
        valid_vec[2] = c_reg.valid;
        valid_vec[3] = d_reg.valid;
        for (int i = 0; i <= ITER; i++)
        begin
            valid_vec[i + 4] = it_reg[i].valid;
        end
    end

`ifndef SYNTHESIS
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> res_re == 32'sd0 && res_im == 32'sd0 && !saturated)
        else $error("zero divisor result not clean");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_vec) && out_valid)
        else $error("pipeline moved during stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> a_reg.valid)
        else $error("accepted item lost at entry");

    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && it_reg[ITER].valid |=> out_valid)
        else $error("finished item not presented");
`endif

endmodule
